@@ hw/rtl/config_image_validator_assert.svh @@
// Assertion macros used by the image validator RTL.
`ifndef CONFIG_IMAGE_VALIDATOR_ASSERT_SVH
`define CONFIG_IMAGE_VALIDATOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define CIV_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("config_image_validator: assertion failed");

// Condition that must hold in the cycle after the trigger.
`define CIV_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("config_image_validator: assertion failed");

`endif

@@ hw/rtl/civ_pkg.sv @@
// Types, constants and the CRC step function of the image validator.
`default_nettype none

package civ_pkg;

  localparam int unsigned RegionBytesDef = 4096;
  localparam int unsigned HeaderBytes    = 20;

  // Header byte counts at which each header word is complete.
  localparam int unsigned MagicEnd   = 4;
  localparam int unsigned VersionEnd = 8;
  localparam int unsigned SizeEnd    = 12;
  localparam int unsigned CrcEnd     = 16;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  localparam logic [31:0] MagicReset  = 32'h0000_0000;
  localparam logic [7:0]  NewestReset = 8'd5;

  typedef enum logic [0:0] {
    CfgMagic  = 1'b0,
    CfgNewest = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StBadMagic    = 3'd1,
    StBadVersion  = 3'd2,
    StBadSize     = 3'd3,
    StCrcMismatch = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PhIdle    = 4'b0001,
    PhHeader  = 4'b0010,
    PhPayload = 4'b0100,
    PhDone    = 4'b1000
  } phase_e;

  // Packed from the top down, so status lands in the lowest bits.
  typedef struct packed {
    logic [31:0] computed_crc;
    logic [31:0] payload_bytes;
    logic [31:0] schema_version;
    status_e     status;
  } result_t;

  // One byte of reflected CRC-32, bit at a time.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/config_image_validator.sv @@
// Settings image validator: header checks and payload CRC-32 over a byte stream.
//
//  Channel   Dir  Handshake                     Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: data_byte; tuser: first
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: status, version, size, crc
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One byte is taken per cycle; the header parse and a byte-wide CRC-32 step update
// the image state in the cycle of the transfer, and a verdict lands in the output
// register at the same edge, or in the skid register while the output is held.
// Input thus continues while a verdict waits and stalls only while both are full.
// Reset clears the image state and loads the register defaults; no clearing pass.
`default_nettype none

module config_image_validator #(
  parameter int unsigned REGION_BYTES = civ_pkg::RegionBytesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] first
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [2:0] status, [34:3] schema_version, [66:35] payload_bytes,
  // [98:67] computed_crc, [103:99] zero
  output logic [103:0]      m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [0:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int unsigned CntW       = $clog2(REGION_BYTES + 1);
  localparam logic [31:0] MaxPayload = 32'(REGION_BYTES - civ_pkg::HeaderBytes);
  localparam int unsigned PadW       = 104 - $bits(civ_pkg::result_t);

  logic [31:0]      magic_q;
  logic [7:0]       newest_q;
  civ_pkg::phase_e  phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [31:0]      word_q, word_d;
  logic [31:0]      ver_q, ver_d;
  logic [31:0]      size_q, size_d;
  logic [31:0]      exp_q, exp_d;
  logic [31:0]      crc_q, crc_d;

  civ_pkg::result_t res_d, out_q, skid_q;
  logic             res_vld;
  logic             out_vld_q, skid_vld_q;
  logic             in_fire, out_fire;

  assign s_axis_tready = !skid_vld_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_q};
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q  <= civ_pkg::MagicReset;
      newest_q <= civ_pkg::NewestReset;
    end else if (cfg_valid_i) begin
      case (civ_pkg::cfg_index_e'(cfg_index_i))
        civ_pkg::CfgMagic:  magic_q  <= cfg_data_i;
        civ_pkg::CfgNewest: newest_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    civ_pkg::phase_e  e_phase;
    logic [CntW-1:0]  e_cnt;
    logic [31:0]      e_word, e_ver, e_size, e_exp, e_crc;
    logic [CntW-1:0]  c;
    logic [31:0]      w;
    logic [31:0]      crc_n;
    logic             emit;
    civ_pkg::status_e st;
    logic [31:0]      crc_out;

    // A first flag restarts the image as if from a cleared state.
    if (s_axis_tuser) begin
      e_phase = civ_pkg::PhHeader;
      e_cnt   = '0;
      e_word  = '0;
      e_ver   = '0;
      e_size  = '0;
      e_exp   = '0;
      e_crc   = civ_pkg::CrcInit;
    end else begin
      e_phase = phase_q;
      e_cnt   = cnt_q;
      e_word  = word_q;
      e_ver   = ver_q;
      e_size  = size_q;
      e_exp   = exp_q;
      e_crc   = crc_q;
    end

    c       = e_cnt + CntW'(1);
    w       = {s_axis_tdata, e_word[31:8]};
    crc_n   = civ_pkg::crc_byte(e_crc, s_axis_tdata);
    emit    = 1'b0;
    st      = civ_pkg::StOk;
    crc_out = '0;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    ver_d   = ver_q;
    size_d  = size_q;
    exp_d   = exp_q;
    crc_d   = crc_q;

    if (in_fire) begin
      phase_d = e_phase;
      cnt_d   = e_cnt;
      word_d  = e_word;
      ver_d   = e_ver;
      size_d  = e_size;
      exp_d   = e_exp;
      crc_d   = e_crc;
      case (e_phase)
        civ_pkg::PhHeader: begin
          word_d = w;
          cnt_d  = c;
          if (c == CntW'(civ_pkg::MagicEnd)) begin
            if (w != magic_q) begin
              emit = 1'b1;
              st   = civ_pkg::StBadMagic;
            end
          end else if (c == CntW'(civ_pkg::VersionEnd)) begin
            ver_d = w;
            if (w == '0 || w > {24'b0, newest_q}) begin
              emit = 1'b1;
              st   = civ_pkg::StBadVersion;
            end
          end else if (c == CntW'(civ_pkg::SizeEnd)) begin
            size_d = w;
            if (w == '0 || w > MaxPayload) begin
              emit = 1'b1;
              st   = civ_pkg::StBadSize;
            end
          end else if (c == CntW'(civ_pkg::CrcEnd)) begin
            exp_d = w;
          end
          if (!emit && c >= CntW'(civ_pkg::HeaderBytes)) begin
            phase_d = civ_pkg::PhPayload;
            cnt_d   = '0;
            crc_d   = civ_pkg::CrcInit;
          end
        end
        civ_pkg::PhPayload: begin
          crc_d = crc_n;
          cnt_d = c;
          if (32'(c) >= e_size) begin
            emit    = 1'b1;
            crc_out = ~crc_n;
            st      = (~crc_n == e_exp) ? civ_pkg::StOk : civ_pkg::StCrcMismatch;
          end
        end
        default: ;
      endcase
      if (emit) begin
        phase_d = civ_pkg::PhDone;
      end
    end

    res_vld              = emit;
    res_d.status         = st;
    res_d.schema_version = ver_d;
    res_d.payload_bytes  = size_d;
    res_d.computed_crc   = crc_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= civ_pkg::PhIdle;
      cnt_q   <= '0;
      word_q  <= '0;
      ver_q   <= '0;
      size_q  <= '0;
      exp_q   <= '0;
      crc_q   <= civ_pkg::CrcInit;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      word_q  <= word_d;
      ver_q   <= ver_d;
      size_q  <= size_d;
      exp_q   <= exp_d;
      crc_q   <= crc_d;
    end
  end

  // Output register with a skid stage; the skid entry drains first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_fire) begin
      out_vld_q <= res_vld;
    end else if (res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_fire) begin
      if (res_vld) begin
        out_q <= res_d;
      end
    end else if (res_vld) begin
      skid_q <= res_d;
    end
  end

`include "config_image_validator_assert.svh"

  `CIV_ASSERT(a_skid_implies_out, !skid_vld_q || out_vld_q)
  `CIV_ASSERT(a_payload_count_below_size,
              phase_q != civ_pkg::PhPayload || 32'(cnt_q) < size_q)
  `CIV_ASSERT(a_payload_size_in_range,
              phase_q != civ_pkg::PhPayload || (size_q != '0 && size_q <= MaxPayload))
  `CIV_ASSERT_NEXT(a_skid_fill_keeps_out, out_vld_q && !m_axis_tready && res_vld,
                   out_vld_q && skid_vld_q)

endmodule

`default_nettype wire
